// File: hdl/uale_pkg.sv
// uale_pkg: shared types, codes and the microprogram of the array list engine
// used by uale_seq, uale_dpath and unordered_array_list_engine; no dependencies
package uale_pkg;

  // step counter width and microprogram addresses
  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] U_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] U_DONE   = 5'd1;
  localparam logic [UPC_W-1:0] U_DWAIT  = 5'd2;
  localparam logic [UPC_W-1:0] U_FULL   = 5'd3;
  localparam logic [UPC_W-1:0] U_RANGE  = 5'd4;
  localparam logic [UPC_W-1:0] U_NFND   = 5'd5;
  localparam logic [UPC_W-1:0] U_APP    = 5'd6;
  localparam logic [UPC_W-1:0] U_APP2   = 5'd7;
  localparam logic [UPC_W-1:0] U_INS    = 5'd8;
  localparam logic [UPC_W-1:0] U_INS1   = 5'd9;
  localparam logic [UPC_W-1:0] U_ILOOP  = 5'd10;
  localparam logic [UPC_W-1:0] U_IWR    = 5'd11;
  localparam logic [UPC_W-1:0] U_IPUT   = 5'd12;
  localparam logic [UPC_W-1:0] U_REPL   = 5'd13;
  localparam logic [UPC_W-1:0] U_REPL2  = 5'd14;
  localparam logic [UPC_W-1:0] U_RMAT   = 5'd15;
  localparam logic [UPC_W-1:0] U_DROP   = 5'd16;
  localparam logic [UPC_W-1:0] U_DROP2  = 5'd17;
  localparam logic [UPC_W-1:0] U_SRCH   = 5'd18;
  localparam logic [UPC_W-1:0] U_SLOOP  = 5'd19;
  localparam logic [UPC_W-1:0] U_SCMP   = 5'd20;
  localparam logic [UPC_W-1:0] U_SFND   = 5'd21;
  localparam logic [UPC_W-1:0] U_SDONE  = 5'd22;

  // operation codes
  localparam logic [2:0] OP_INS   = 3'd0;
  localparam logic [2:0] OP_APP   = 3'd1;
  localparam logic [2:0] OP_RMAT  = 3'd2;
  localparam logic [2:0] OP_REPL  = 3'd3;
  localparam logic [2:0] OP_SRCH  = 3'd4;
  localparam logic [2:0] OP_RMVAL = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NFND  = 2'd3;

  // jump conditions
  localparam logic [3:0] C_ALWAYS     = 4'd0;
  localparam logic [3:0] C_FULL       = 4'd1;
  localparam logic [3:0] C_POS_GT_CNT = 4'd2;
  localparam logic [3:0] C_POS_GE_CNT = 4'd3;
  localparam logic [3:0] C_IDX_LE_POS = 4'd4;
  localparam logic [3:0] C_IDX_GE_CNT = 4'd5;
  localparam logic [3:0] C_NOMATCH    = 4'd6;
  localparam logic [3:0] C_IS_RMV     = 4'd7;
  localparam logic [3:0] C_OUT_FREE   = 4'd8;

  // read address select
  localparam logic [1:0] RA_IDX   = 2'd0;
  localparam logic [1:0] RA_IDXM1 = 2'd1;
  localparam logic [1:0] RA_CNTM1 = 2'd2;

  // write address select
  localparam logic [1:0] WA_IDX   = 2'd0;
  localparam logic [1:0] WA_POS   = 2'd1;
  localparam logic [1:0] WA_CNT   = 2'd2;
  localparam logic [1:0] WA_FOUND = 2'd3;

  // write data select
  localparam logic WD_VAL = 1'b0;
  localparam logic WD_RD  = 1'b1;

  // index register operations
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_CLR   = 3'd1;
  localparam logic [2:0] IDX_INC   = 3'd2;
  localparam logic [2:0] IDX_DEC   = 3'd3;
  localparam logic [2:0] IDX_LDCNT = 3'd4;

  // count register operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // found register operations
  localparam logic [1:0] FND_HOLD  = 2'd0;
  localparam logic [1:0] FND_LDIDX = 2'd1;
  localparam logic [1:0] FND_LDPOS = 2'd2;

  // one control word of the microprogram
  typedef struct packed {
    logic [3:0]       cond;
    logic [UPC_W-1:0] target;
    logic             disp;
    logic             emit;
    logic [1:0]       ra_sel;
    logic             we;
    logic [1:0]       wa_sel;
    logic             wd_sel;
    logic [2:0]       idx_op;
    logic [1:0]       cnt_op;
    logic [1:0]       fnd_op;
    logic             st_set;
    logic [1:0]       st_val;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic idx_le_pos;
    logic idx_ge_cnt;
    logic nomatch;
    logic is_rmv;
    logic out_free;
  } flags_t;

  // first step of each operation
  function automatic logic [UPC_W-1:0] uale_entry(input logic [2:0] f);
    logic [UPC_W-1:0] a;
    unique case (f)
      OP_INS:   a = U_INS;
      OP_APP:   a = U_APP;
      OP_RMAT:  a = U_RMAT;
      OP_REPL:  a = U_REPL;
      OP_SRCH:  a = U_SRCH;
      OP_RMVAL: a = U_SRCH;
      default:  a = U_DONE;
    endcase
    return a;
  endfunction

  // microprogram rom; an all-zero word jumps to idle and does nothing
  function automatic ctrl_t uale_rom(input logic [UPC_W-1:0] a);
    ctrl_t w;
    w = '0;
    unique case (a)
      U_IDLE: begin
        w.target = U_IDLE;
        w.disp   = 1'b1;
      end
      U_DONE: begin
        w.cond   = C_OUT_FREE;
        w.target = U_IDLE;
        w.emit   = 1'b1;
      end
      U_DWAIT: begin
        w.target = U_DONE;
      end
      U_FULL: begin
        w.st_set = 1'b1;
        w.st_val = ST_FULL;
        w.target = U_DONE;
      end
      U_RANGE: begin
        w.st_set = 1'b1;
        w.st_val = ST_RANGE;
        w.target = U_DONE;
      end
      U_NFND: begin
        w.st_set = 1'b1;
        w.st_val = ST_NFND;
        w.target = U_DONE;
      end
      U_APP: begin
        w.cond   = C_FULL;
        w.target = U_FULL;
      end
      U_APP2: begin
        w.we     = 1'b1;
        w.wa_sel = WA_CNT;
        w.wd_sel = WD_VAL;
        w.cnt_op = CNT_INC;
        w.target = U_DONE;
      end
      U_INS: begin
        w.cond   = C_FULL;
        w.target = U_FULL;
      end
      U_INS1: begin
        w.cond   = C_POS_GT_CNT;
        w.target = U_RANGE;
        w.idx_op = IDX_LDCNT;
      end
      U_ILOOP: begin
        w.cond   = C_IDX_LE_POS;
        w.target = U_IPUT;
        w.ra_sel = RA_IDXM1;
      end
      U_IWR: begin
        w.we     = 1'b1;
        w.wa_sel = WA_IDX;
        w.wd_sel = WD_RD;
        w.idx_op = IDX_DEC;
        w.target = U_ILOOP;
      end
      U_IPUT: begin
        w.we     = 1'b1;
        w.wa_sel = WA_POS;
        w.wd_sel = WD_VAL;
        w.cnt_op = CNT_INC;
        w.target = U_DONE;
      end
      U_REPL: begin
        w.cond   = C_POS_GE_CNT;
        w.target = U_RANGE;
      end
      U_REPL2: begin
        w.we     = 1'b1;
        w.wa_sel = WA_POS;
        w.wd_sel = WD_VAL;
        w.target = U_DONE;
      end
      U_RMAT: begin
        w.cond   = C_POS_GE_CNT;
        w.target = U_RANGE;
        w.fnd_op = FND_LDPOS;
      end
      U_DROP: begin
        w.ra_sel = RA_CNTM1;
        w.target = U_DROP2;
      end
      U_DROP2: begin
        w.we     = 1'b1;
        w.wa_sel = WA_FOUND;
        w.wd_sel = WD_RD;
        w.cnt_op = CNT_DEC;
        w.target = U_DONE;
      end
      U_SRCH: begin
        w.idx_op = IDX_CLR;
        w.target = U_SLOOP;
      end
      U_SLOOP: begin
        w.cond   = C_IDX_GE_CNT;
        w.target = U_NFND;
        w.ra_sel = RA_IDX;
      end
      U_SCMP: begin
        w.fnd_op = FND_LDIDX;
        w.idx_op = IDX_INC;
        w.cond   = C_NOMATCH;
        w.target = U_SLOOP;
      end
      U_SFND: begin
        w.cond   = C_IS_RMV;
        w.target = U_DROP;
      end
      U_SDONE: begin
        w.target = U_DONE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/uale_seq.sv
// uale_seq: step counter, microprogram rom lookup and conditional jumps
// depends on uale_pkg for the control word, flags and the rom contents
module uale_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [2:0]                      in_func,
  input  uale_pkg::flags_t                flags,
  output uale_pkg::ctrl_t                 ctrl,
  output logic                            in_ready
);
  import uale_pkg::*;

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  ctrl_t            word;
  logic             taken;

  // fetch the control word of the current step
  assign word     = uale_rom(upc_r);
  assign ctrl     = word;
  assign in_ready = word.disp;

  // jump condition select
  always_comb begin
    unique case (word.cond)
      C_ALWAYS:     taken = 1'b1;
      C_FULL:       taken = flags.full;
      C_POS_GT_CNT: taken = flags.pos_gt_cnt;
      C_POS_GE_CNT: taken = flags.pos_ge_cnt;
      C_IDX_LE_POS: taken = flags.idx_le_pos;
      C_IDX_GE_CNT: taken = flags.idx_ge_cnt;
      C_NOMATCH:    taken = flags.nomatch;
      C_IS_RMV:     taken = flags.is_rmv;
      C_OUT_FREE:   taken = flags.out_free;
      default:      taken = 1'b0;
    endcase
  end

  // next step: dispatch on a new item, else jump or fall through
  always_comb begin
    priority if (word.disp && in_valid) begin
      upc_nxt = uale_entry(in_func);
    end else if (taken) begin
      upc_nxt = word.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: hdl/uale_dpath.sv
// uale_dpath: item store, count, index and found registers, result register
// depends on uale_pkg; steered each cycle by the control word from uale_seq
module uale_dpath #(
  parameter int CAPACITY = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  uale_pkg::ctrl_t        ctrl,
  input  logic                   accept,
  input  logic [2:0]             in_func,
  input  logic [6:0]             in_position,
  input  logic signed [31:0]     in_item_value,
  output uale_pkg::flags_t       flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [5:0]             out_found_index,
  output logic [6:0]             out_list_length
);
  import uale_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  // request registers
  logic [2:0]    op_r;
  logic [6:0]    pos_r;
  logic [31:0]   val_r;
  logic [1:0]    status_r;

  // working registers
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_nxt;
  logic [AW-1:0] found_r;

  // item store
  logic [31:0]   mem_r [CAPACITY];
  logic [31:0]   rdata_r;
  logic [AW-1:0] ra;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  // result register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [5:0]    out_found_r;
  logic [6:0]    out_len_r;
  logic          out_free;
  logic          emit_go;
  logic          rep_found;

  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic [PW-1:0] idx_x;

  assign pos_x = PW'(pos_r);
  assign cnt_x = PW'(cnt_r);
  assign idx_x = PW'(idx_r);

  // flags for the jump conditions
  assign out_free = !out_valid_r || out_ready;
  always_comb begin
    flags.full       = (cnt_r == CW'(CAPACITY));
    flags.pos_gt_cnt = (pos_x > cnt_x);
    flags.pos_ge_cnt = (pos_x >= cnt_x);
    flags.idx_le_pos = (idx_x <= pos_x);
    flags.idx_ge_cnt = (idx_r >= cnt_r);
    flags.nomatch    = (rdata_r != val_r);
    flags.is_rmv     = (op_r == OP_RMVAL);
    flags.out_free   = out_free;
  end

  // store address and data select
  always_comb begin
    unique case (ctrl.ra_sel)
      RA_IDX:   ra = AW'(idx_r);
      RA_IDXM1: ra = AW'(idx_r - CW'(1));
      RA_CNTM1: ra = AW'(cnt_r - CW'(1));
      default:  ra = AW'(idx_r);
    endcase
    unique case (ctrl.wa_sel)
      WA_IDX:   wa = AW'(idx_r);
      WA_POS:   wa = AW'(pos_r);
      WA_CNT:   wa = AW'(cnt_r);
      WA_FOUND: wa = found_r;
      default:  wa = AW'(idx_r);
    endcase
    wd = (ctrl.wd_sel == WD_RD) ? rdata_r : val_r;
  end

  // store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem_r[wa] <= wd;
    end
    rdata_r <= mem_r[ra];
  end

  // index and count updates
  always_comb begin
    unique case (ctrl.idx_op)
      IDX_HOLD:  idx_nxt = idx_r;
      IDX_CLR:   idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + CW'(1);
      IDX_DEC:   idx_nxt = idx_r - CW'(1);
      IDX_LDCNT: idx_nxt = cnt_r;
      default:   idx_nxt = idx_r;
    endcase
    unique case (ctrl.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers of the running request
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      op_r     <= in_func;
      pos_r    <= in_position;
      val_r    <= in_item_value;
      status_r <= ST_OK;
    end else if (ctrl.st_set) begin
      status_r <= ctrl.st_val;
    end
    unique case (ctrl.fnd_op)
      FND_LDIDX: found_r <= AW'(idx_r);
      FND_LDPOS: found_r <= AW'(pos_r);
      default:   found_r <= found_r;
    endcase
  end

  // result register, free again once the item is taken
  assign emit_go   = ctrl.emit && out_free;
  assign rep_found = (status_r == ST_OK) && ((op_r == OP_SRCH) || (op_r == OP_RMVAL));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status_r <= status_r;
      out_found_r  <= rep_found ? 6'(found_r) : 6'd0;
      out_len_r    <= 7'(cnt_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_list_length = out_len_r;

  // count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("item count above capacity");

  // writes land only on held entries or the first free one
  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.we |-> (CW'(wa) <= cnt_r))
    else $error("store write beyond list end");

  // a miss never reports an index
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_NFND)) |-> (out_found_r == 6'd0))
    else $error("not found result with nonzero index");

  // a full status only when the list really is full
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && (status_r == ST_FULL) |-> (cnt_r == CW'(CAPACITY)))
    else $error("full status below capacity");

endmodule

// File: hdl/unordered_array_list_engine.sv
// Unordered array list engine: a CAPACITY-entry list of signed 32-bit items
// with insert, append, remove, replace, search and remove-by-value. A request
// is taken only while the sequencer sits in its idle step and gives one result
// item. Insert and search walk the entries one at a time, a read step and then
// a compare or write step for each entry, because the store has one read port
// with registered data. The result register lets a finished result wait for
// the taker while the next request is accepted. No clearing pass after reset.
module unordered_array_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic [6:0]         out_list_length
);
  import uale_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  assign accept = in_valid && in_ready;

  // microprogram sequencer
  uale_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .flags    (flags),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // store and registers
  uale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .accept          (accept),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .flags           (flags),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_list_length (out_list_length)
  );

endmodule

// File: verif/tb_unordered_array_list_engine.sv
`timescale 1ns / 100ps
// tb_unordered_array_list_engine: self-checking bench for the array list engine
// with a list predictor, a valid/ready driver and a result monitor
// depends on uale_pkg and unordered_array_list_engine
module tb_unordered_array_list_engine;
  import uale_pkg::*;

  localparam int LIST_DEPTH     = 64;
  localparam int RANDOM_ITEMS   = 900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  // func codes the block treats as no operation
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  typedef enum int {GEN_FILL, GEN_DRAIN, GEN_MIXED, GEN_NOISE} gen_mode_e;

  typedef struct {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;
  } list_req_t;

  typedef struct {
    logic [1:0] status;
    logic [5:0] found;
    logic [6:0] length;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_func = '0;
  logic [6:0]         in_position = '0;
  logic signed [31:0] in_item_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [5:0]         out_found_index;
  logic [6:0]         out_list_length;

  // predicted list contents and length
  logic signed [31:0] shadow_items [LIST_DEPTH];
  int                 shadow_count = 0;

  list_req_t    pending_reqs [$];
  list_result_t expected_results [$];
  int           mismatch_count = 0;
  int           idle_cycles = 0;

  always #1 clk = ~clk;

  unordered_array_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_found_index(out_found_index),
    .out_list_length(out_list_length)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // the last item fills the hole, so order is not kept
  function automatic void drop_entry(input int idx);
    shadow_items[idx] = shadow_items[shadow_count - 1];
    shadow_count--;
  endfunction

  // list predictor: applies one request and gives its result
  function automatic list_result_t apply_list_op(input list_req_t r);
    list_result_t res;
    int k;
    int p;
    bit hit;
    res.status = ST_OK;
    res.found  = '0;
    p   = r.position;
    hit = 1'b0;
    case (r.func)
      OP_INS: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (p > shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (k = shadow_count; k > p; k--) shadow_items[k] = shadow_items[k-1];
          shadow_items[p] = r.value;
          shadow_count++;
        end
      end
      OP_APP: begin
        if (shadow_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_items[shadow_count] = r.value;
          shadow_count++;
        end
      end
      OP_RMAT: begin
        if (p >= shadow_count) res.status = ST_RANGE;
        else drop_entry(p);
      end
      OP_REPL: begin
        if (p >= shadow_count) res.status = ST_RANGE;
        else shadow_items[p] = r.value;
      end
      OP_SRCH, OP_RMVAL: begin
        for (k = 0; k < shadow_count; k++) begin
          if (!hit && shadow_items[k] == r.value) begin
            hit       = 1'b1;
            res.found = k[5:0];
          end
        end
        if (!hit) res.status = ST_NFND;
        else if (r.func == OP_RMVAL) drop_entry(res.found);
      end
      default: ;
    endcase
    res.length = shadow_count[6:0];
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap(input bit steady);
    int w;
    w = $urandom_range(0, 99);
    if (steady || w < 65) return 0;
    if (w < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_req(input logic [2:0] f, input logic [6:0] p,
                                    input logic signed [31:0] v);
    list_req_t r;
    r.func     = f;
    r.position = p;
    r.value    = v;
    pending_reqs.push_back(r);
  endfunction

  // random request steered by the live predicted list
  function automatic list_req_t make_request(input gen_mode_e mode);
    list_req_t r;
    int w;
    int hit_pct;
    w = $urandom_range(0, 99);
    case (mode)
      GEN_FILL:  r.func = (w < 45) ? OP_INS : (w < 90) ? OP_APP
                                   : 3'($urandom_range(OP_INS, OP_RMVAL));
      GEN_DRAIN: r.func = (w < 45) ? OP_RMAT : (w < 90) ? OP_RMVAL
                                   : 3'($urandom_range(OP_INS, OP_RMVAL));
      GEN_MIXED: r.func = 3'($urandom_range(OP_INS, OP_RMVAL));
      default:   r.func = 3'($urandom_range(OP_INS, OP_NOP7));
    endcase

    // position: mostly valid, some at the boundary, some anywhere
    w = $urandom_range(0, 99);
    if (mode == GEN_NOISE || w >= 93) begin
      r.position = 7'($urandom_range(0, LIST_DEPTH));
    end else if (w >= 85) begin
      r.position = 7'(shadow_count);
    end else if (r.func == OP_INS) begin
      r.position = 7'($urandom_range(0, shadow_count));
    end else begin
      r.position = (shadow_count > 0) ? 7'($urandom_range(0, shadow_count - 1)) : '0;
    end

    // value: copy of a held item for hits, corner values, or anything
    hit_pct = (r.func == OP_SRCH || r.func == OP_RMVAL) ? 75 : 20;
    if (mode != GEN_NOISE && shadow_count > 0 && $urandom_range(0, 99) < hit_pct) begin
      r.value = shadow_items[$urandom_range(0, shadow_count - 1)];
    end else if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0:       r.value = 32'sd0;
        1:       r.value = -32'sd1;
        2:       r.value = 32'sh7fffffff;
        3:       r.value = 32'sh80000000;
        default: r.value = 32'sd1;
      endcase
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  // driver: presents pending items, predicts each one on acceptance
  int tx_gap = 0;
  bit tx_steady = 1'b0;
  always @(posedge clk) begin : req_driver
    list_req_t taken;
    list_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
      if (in_valid && in_ready) begin
        taken.func     = in_func;
        taken.position = in_position;
        taken.value    = in_item_value;
        expected_results.push_back(apply_list_op(taken));
        tx_gap = pick_gap(tx_steady);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_func       <= nxt.func;
          in_position   <= nxt.position;
          in_item_value <= nxt.value;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction
  int rx_stall = 0;
  bit rx_steady = 1'b0;
  always @(posedge clk) begin : result_monitor
    list_result_t want;
    if (rst_n) begin
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
          if (out_found_index !== want.found)
            report_mismatch($sformatf("found_index %0d, predicted %0d",
                                      out_found_index, want.found));
          if (out_list_length !== want.length)
            report_mismatch($sformatf("list_length %0d, predicted %0d",
                                      out_list_length, want.length));
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall = pick_gap(rx_steady);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_unordered_array_list_engine failed");
      $finish;
    end
  end

  initial begin : stimulus
    int gen_count;
    int mode_len;
    int w;
    gen_mode_e mode;

    // directed: empty-list errors, corner values, duplicates, no-op codes
    queue_req(OP_RMAT,  7'd0,  32'sd0);
    queue_req(OP_REPL,  7'd0,  32'sd9);
    queue_req(OP_SRCH,  7'd0,  32'sd5);
    queue_req(OP_RMVAL, 7'd0,  32'sd5);
    queue_req(OP_INS,   7'd1,  32'sd3);
    queue_req(OP_INS,   7'd0,  32'sh7fffffff);
    queue_req(OP_APP,   7'd64, 32'sh80000000);
    queue_req(OP_INS,   7'd2,  -32'sd1);
    queue_req(OP_INS,   7'd0,  32'sd0);
    queue_req(OP_INS,   7'd64, 32'sd7);
    queue_req(OP_SRCH,  7'd0,  -32'sd1);
    queue_req(OP_APP,   7'd0,  -32'sd1);
    queue_req(OP_SRCH,  7'd64, -32'sd1);
    queue_req(OP_REPL,  7'd1,  32'sh5a5a5a5a);
    queue_req(OP_REPL,  7'd64, 32'sd1);
    queue_req(OP_RMAT,  7'd0,  32'sd0);
    queue_req(OP_RMVAL, 7'd0,  32'sh80000000);
    queue_req(OP_NOP6,  7'd64, 32'sh7fffffff);
    queue_req(OP_NOP7,  7'd5,  -32'sd1);
    queue_req(OP_RMAT,  7'd3,  32'sd0);
    queue_req(OP_SRCH,  7'd0,  32'sh5a5a5a5a);
    queue_req(OP_RMVAL, 7'd0,  32'sh12345678);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // random: runs of filling, draining and mixed traffic, a little noise
    gen_count = 0;
    while (gen_count < RANDOM_ITEMS) begin
      w = $urandom_range(0, 99);
      if (w < 35) mode = GEN_FILL;
      else if (w < 65) mode = GEN_DRAIN;
      else if (w < 90) mode = GEN_MIXED;
      else mode = GEN_NOISE;
      mode_len = (mode == GEN_NOISE) ? $urandom_range(10, 25) : $urandom_range(30, 100);
      repeat (mode_len) begin
        while (pending_reqs.size() >= 2) @(negedge clk);
        pending_reqs.push_back(make_request(mode));
        gen_count++;
      end
    end

    // wait for every result, then a quiet stretch for strays
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_unordered_array_list_engine passed");
    end else begin
      $display("tb_unordered_array_list_engine failed");
    end
    $finish;
  end

endmodule
